@@ rtl/core/rexmm_pkg.sv @@
// ----------------------------------------------------------------------------
// rexmm_pkg
// shared constants, op codes, register indexes and the sequencer state type
// ----------------------------------------------------------------------------
`default_nettype none
package rexmm_pkg;

  localparam int ROWS    = 64;
  localparam int EXPERTS = 8;
  localparam int INNER   = 32;
  localparam int OUTS    = 32;

  localparam int ROW_W  = 6;
  localparam int EX_W   = 3;
  localparam int K_W    = 5;
  localparam int COL_W  = 5;
  localparam int VAL_W  = 16;
  localparam int CNT_W  = 7;
  localparam int ACC_W  = 37;
  localparam int PROD_W = 32;

  localparam int ACT_AW = ROW_W + K_W;
  localparam int WGT_AW = EX_W + K_W + COL_W;
  localparam int OUT_AW = ROW_W + COL_W;

  localparam logic [2:0] OP_LOAD_ACT   = 3'd0;
  localparam logic [2:0] OP_LOAD_WGT   = 3'd1;
  localparam logic [2:0] OP_LOAD_ROUTE = 3'd2;
  localparam logic [2:0] OP_RUN        = 3'd3;
  localparam logic [2:0] OP_READ       = 3'd4;

  localparam logic [2:0] CFG_NUM_ROWS     = 3'd0;
  localparam logic [2:0] CFG_INNER_LEN    = 3'd1;
  localparam logic [2:0] CFG_OUT_LEN      = 3'd2;
  localparam logic [2:0] CFG_NUM_EXPERTS  = 3'd3;
  localparam logic [2:0] CFG_RANGE_ENABLE = 3'd4;
  localparam logic [2:0] CFG_EXPERT_FIRST = 3'd5;
  localparam logic [2:0] CFG_EXPERT_LAST  = 3'd6;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_SCAN,
    ST_CHECK,
    ST_PREFIX,
    ST_SORT,
    ST_ROW,
    ST_ROW_WAIT,
    ST_MAC,
    ST_DRAIN
  } state_t;

endpackage
`default_nettype wire

@@ rtl/core/routed_expert_matrix_multiply.sv @@
// ----------------------------------------------------------------------------
// routed_expert_matrix_multiply
// grouped matrix multiply over per-row routed experts, memory based
// ----------------------------------------------------------------------------
// Loads (activation, weight, route) are accepted even while a result word waits
// at the output. A read returns the word through a registered output memory read.
// A run is sequenced over the memories: route scan, check, prefix sum over the
// experts, sort, then a step over the buckets of each expert in the range, per
// routed row a fetch of the row id and per column a pass through the single
// multiply accumulate pipe (read, multiply, add). The output memory is cleared
// after reset, one entry a cycle, over every one of its entries; no word is
// accepted during that pass, configuration writes are taken always.
`default_nettype none
module routed_expert_matrix_multiply
  import rexmm_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    cfg_we,
  input  wire logic [2:0]              cfg_index,
  input  wire logic [6:0]              cfg_wdata,
  input  wire logic                    in_valid,
  output logic                         in_stall,
  input  wire logic [2:0]              in_op,
  input  wire logic [ROW_W-1:0]        in_row,
  input  wire logic [EX_W-1:0]         in_expert,
  input  wire logic [K_W-1:0]          in_inner_index,
  input  wire logic [COL_W-1:0]        in_column,
  input  wire logic signed [VAL_W-1:0] in_value,
  output logic                         out_valid,
  input  wire logic                    out_stall,
  output logic                         out_status,
  output logic [CNT_W-1:0]             out_rows_done,
  output logic signed [ACC_W-1:0]      out_result
);

  // configuration registers
  logic [6:0] num_rows_r;
  logic [5:0] inner_len_r, out_len_r;
  logic [3:0] num_experts_r, expert_first_r, expert_last_r;
  logic       range_enable_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_rows_r     <= 7'd64;
      inner_len_r    <= 6'd32;
      out_len_r      <= 6'd32;
      num_experts_r  <= 4'd8;
      range_enable_r <= 1'b0;
      expert_first_r <= 4'd0;
      expert_last_r  <= 4'd8;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_NUM_ROWS:     num_rows_r     <= cfg_wdata;
        CFG_INNER_LEN:    inner_len_r    <= cfg_wdata[5:0];
        CFG_OUT_LEN:      out_len_r      <= cfg_wdata[5:0];
        CFG_NUM_EXPERTS:  num_experts_r  <= cfg_wdata[3:0];
        CFG_RANGE_ENABLE: range_enable_r <= cfg_wdata[0];
        CFG_EXPERT_FIRST: expert_first_r <= cfg_wdata[3:0];
        CFG_EXPERT_LAST:  expert_last_r  <= cfg_wdata[3:0];
        default: ;
      endcase
    end
  end

  // memory ports
  logic                    act_we, wgt_we, rte_we, grp_we, out_we;
  logic [ACT_AW-1:0]       act_waddr, act_raddr;
  logic [WGT_AW-1:0]       wgt_waddr, wgt_raddr;
  logic [ROW_W-1:0]        rte_waddr, rte_raddr, grp_waddr, grp_raddr, grp_wdata;
  logic [OUT_AW-1:0]       out_waddr, out_raddr;
  logic [ACC_W-1:0]        out_wdata, out_rdata;
  logic [VAL_W-1:0]        act_rdata, wgt_rdata, rte_rdata;
  logic [ROW_W-1:0]        grp_rdata;

  rexmm_ram #(.WIDTH(VAL_W), .DEPTH(ROWS*INNER)) u_act (
    .clk, .we(act_we), .waddr(act_waddr), .wdata(in_value),
    .raddr(act_raddr), .rdata(act_rdata));
  rexmm_ram #(.WIDTH(VAL_W), .DEPTH(EXPERTS*INNER*OUTS)) u_wgt (
    .clk, .we(wgt_we), .waddr(wgt_waddr), .wdata(in_value),
    .raddr(wgt_raddr), .rdata(wgt_rdata));
  rexmm_ram #(.WIDTH(VAL_W), .DEPTH(ROWS)) u_rte (
    .clk, .we(rte_we), .waddr(rte_waddr), .wdata(in_value),
    .raddr(rte_raddr), .rdata(rte_rdata));
  rexmm_ram #(.WIDTH(ROW_W), .DEPTH(ROWS)) u_grp (
    .clk, .we(grp_we), .waddr(grp_waddr), .wdata(grp_wdata),
    .raddr(grp_raddr), .rdata(grp_rdata));
  rexmm_ram #(.WIDTH(ACC_W), .DEPTH(ROWS*OUTS)) u_out (
    .clk, .we(out_we), .waddr(out_waddr), .wdata(out_wdata),
    .raddr(out_raddr), .rdata(out_rdata));

  // sequencer state
  state_t             state_r, state_nxt;
  logic [OUT_AW-1:0]  clr_r, clr_nxt;
  logic [CNT_W-1:0]   b_r, b_nxt, i_r, i_nxt, done_r, done_nxt;
  logic [3:0]         e_r, e_nxt;
  logic [ROW_W-1:0]   row_r, row_nxt, sort_b_r, sort_b_nxt;
  logic [5:0]         j_r, j_nxt, k_r, k_nxt;
  logic               bad_r, bad_nxt, scan_v_r, scan_v_nxt;
  logic               rd_v_r, rd_v_nxt, rd_last_r, rd_last_nxt;
  logic               prod_v_r, prod_last_r;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [ACC_W-1:0]  acc_r, acc_nxt, acc_sum;
  logic [CNT_W-1:0]   cnt_r [EXPERTS], cnt_nxt [EXPERTS];
  logic [CNT_W-1:0]   fill_r [EXPERTS], fill_nxt [EXPERTS];
  logic [CNT_W-1:0]   start_r [EXPERTS+1], start_nxt [EXPERTS+1];

  // result word register
  logic                    out_valid_r, out_status_r;
  logic [CNT_W-1:0]        out_rows_r;
  logic signed [ACC_W-1:0] out_result_r;
  logic                    out_load, load_status;
  logic [CNT_W-1:0]        load_rows;
  logic [ACC_W-1:0]        load_result;

  logic       in_acc, needs_out, cfg_bad, id_ok;
  logic [3:0] e_lo, e_hi;

  assign needs_out = (in_op == OP_RUN) || (in_op == OP_READ);
  assign in_stall  = (state_r != ST_IDLE) || (out_valid_r && out_stall && needs_out);
  assign in_acc    = in_valid && !in_stall;

  // run argument check, ahead of any state change
  always_comb begin
    cfg_bad = (num_rows_r == 7'd0) || (num_rows_r > 7'(ROWS)) ||
              (inner_len_r == 6'd0) || (inner_len_r > 6'(INNER)) ||
              (out_len_r == 6'd0) || (out_len_r > 6'(OUTS)) ||
              (num_experts_r == 4'd0) || (num_experts_r > 4'(EXPERTS));
    if (range_enable_r &&
        ((expert_last_r > num_experts_r) || (expert_first_r > expert_last_r))) begin
      cfg_bad = 1'b1;
    end
  end

  assign e_lo = range_enable_r ? expert_first_r : 4'd0;
  assign e_hi = range_enable_r ? expert_last_r : num_experts_r;

  // route id legal: non-negative and below num_experts
  assign id_ok = (rte_rdata[15:3] == 13'd0) && ({1'b0, rte_rdata[2:0]} < num_experts_r);

  assign acc_sum = prod_v_r ? acc_r + ACC_W'(prod_r) : acc_r;

  always_comb begin
    state_nxt   = state_r;
    clr_nxt     = clr_r;
    b_nxt       = b_r;
    i_nxt       = i_r;
    e_nxt       = e_r;
    done_nxt    = done_r;
    row_nxt     = row_r;
    j_nxt       = j_r;
    k_nxt       = k_r;
    bad_nxt     = bad_r;
    sort_b_nxt  = sort_b_r;
    scan_v_nxt  = 1'b0;
    rd_v_nxt    = 1'b0;
    rd_last_nxt = 1'b0;
    acc_nxt     = acc_sum;
    cnt_nxt     = cnt_r;
    fill_nxt    = fill_r;
    start_nxt   = start_r;

    act_we    = 1'b0;
    wgt_we    = 1'b0;
    rte_we    = 1'b0;
    grp_we    = 1'b0;
    out_we    = 1'b0;
    act_waddr = {in_row, in_inner_index};
    wgt_waddr = {in_expert, in_inner_index, in_column};
    rte_waddr = in_row;
    act_raddr = {row_r, k_r[K_W-1:0]};
    wgt_raddr = {e_r[EX_W-1:0], k_r[K_W-1:0], j_r[COL_W-1:0]};
    rte_raddr = b_r[ROW_W-1:0];
    grp_waddr = fill_r[rte_rdata[2:0]][ROW_W-1:0];
    grp_wdata = sort_b_r;
    grp_raddr = i_r[ROW_W-1:0];
    out_raddr = {in_row, in_column};
    out_waddr = {row_r, j_r[COL_W-1:0]};
    out_wdata = acc_sum;

    out_load    = 1'b0;
    load_status = 1'b0;
    load_rows   = '0;
    load_result = '0;

    case (state_r)
      ST_CLEAR: begin
        out_we    = 1'b1;
        out_waddr = clr_r;
        out_wdata = '0;
        clr_nxt   = clr_r + 1'b1;
        if (clr_r == OUT_AW'(ROWS*OUTS-1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_acc) begin
          case (in_op)
            OP_LOAD_ACT:   act_we = 1'b1;
            OP_LOAD_WGT:   wgt_we = 1'b1;
            OP_LOAD_ROUTE: rte_we = 1'b1;
            OP_READ:       state_nxt = ST_READ;
            OP_RUN: begin
              if (cfg_bad) begin
                out_load    = 1'b1;
                load_status = 1'b1;
              end else begin
                b_nxt        = '0;
                bad_nxt      = 1'b0;
                start_nxt[0] = '0;
                for (int n = 0; n < EXPERTS; n++) begin
                  cnt_nxt[n] = '0;
                end
                state_nxt = ST_SCAN;
              end
            end
            default: ;
          endcase
        end
      end
      ST_READ: begin
        out_load    = 1'b1;
        load_result = out_rdata;
        state_nxt   = ST_IDLE;
      end
      ST_SCAN: begin
        // count each id in the cycle after its route read
        if (scan_v_r) begin
          if (id_ok) begin
            cnt_nxt[rte_rdata[2:0]] = cnt_r[rte_rdata[2:0]] + 1'b1;
          end else begin
            bad_nxt = 1'b1;
          end
        end
        if (b_r < num_rows_r) begin
          scan_v_nxt = 1'b1;
          b_nxt      = b_r + 1'b1;
        end else begin
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (bad_r) begin
          out_load    = 1'b1;
          load_status = 1'b1;
          state_nxt   = ST_IDLE;
        end else begin
          e_nxt     = '0;
          state_nxt = ST_PREFIX;
        end
      end
      ST_PREFIX: begin
        start_nxt[e_r + 4'd1] = start_r[e_r] + cnt_r[e_r[EX_W-1:0]];
        fill_nxt[e_r[EX_W-1:0]] = start_r[e_r];
        e_nxt = e_r + 4'd1;
        if (e_r == 4'(EXPERTS-1)) begin
          b_nxt     = '0;
          state_nxt = ST_SORT;
        end
      end
      ST_SORT: begin
        // stable placement of rows into their expert buckets
        if (scan_v_r) begin
          grp_we = 1'b1;
          fill_nxt[rte_rdata[2:0]] = fill_r[rte_rdata[2:0]] + 1'b1;
        end
        if (b_r < num_rows_r) begin
          scan_v_nxt = 1'b1;
          sort_b_nxt = b_r[ROW_W-1:0];
          b_nxt      = b_r + 1'b1;
        end else begin
          e_nxt     = e_lo;
          i_nxt     = start_r[e_lo];
          done_nxt  = '0;
          state_nxt = ST_ROW;
        end
      end
      ST_ROW: begin
        if (e_r >= e_hi) begin
          out_load  = 1'b1;
          load_rows = done_r;
          state_nxt = ST_IDLE;
        end else if (i_r >= start_r[e_r + 4'd1]) begin
          e_nxt = e_r + 4'd1;
        end else begin
          state_nxt = ST_ROW_WAIT;
        end
      end
      ST_ROW_WAIT: begin
        row_nxt   = grp_rdata;
        j_nxt     = '0;
        k_nxt     = '0;
        acc_nxt   = '0;
        state_nxt = ST_MAC;
      end
      ST_MAC: begin
        rd_v_nxt    = 1'b1;
        rd_last_nxt = (k_r == inner_len_r - 6'd1);
        k_nxt       = k_r + 6'd1;
        if (k_r == inner_len_r - 6'd1) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (prod_v_r && prod_last_r) begin
          out_we  = 1'b1;
          acc_nxt = '0;
          k_nxt   = '0;
          if (j_r == out_len_r - 6'd1) begin
            done_nxt  = done_r + 1'b1;
            i_nxt     = i_r + 1'b1;
            state_nxt = ST_ROW;
          end else begin
            j_nxt     = j_r + 6'd1;
            state_nxt = ST_MAC;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      scan_v_r    <= 1'b0;
      rd_v_r      <= 1'b0;
      prod_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
      for (int n = 0; n < EXPERTS; n++) begin
        cnt_r[n]  <= '0;
        fill_r[n] <= '0;
      end
      for (int n = 0; n <= EXPERTS; n++) begin
        start_r[n] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      scan_v_r    <= scan_v_nxt;
      rd_v_r      <= rd_v_nxt;
      prod_v_r    <= rd_v_r;
      cnt_r       <= cnt_nxt;
      fill_r      <= fill_nxt;
      start_r     <= start_nxt;
      out_valid_r <= out_load || (out_valid_r && out_stall);
    end
  end

  // datapath registers, no reset needed
  always_ff @(posedge clk) begin
    b_r         <= b_nxt;
    i_r         <= i_nxt;
    e_r         <= e_nxt;
    done_r      <= done_nxt;
    row_r       <= row_nxt;
    j_r         <= j_nxt;
    k_r         <= k_nxt;
    bad_r       <= bad_nxt;
    sort_b_r    <= sort_b_nxt;
    rd_last_r   <= rd_last_nxt;
    prod_last_r <= rd_last_r;
    acc_r       <= acc_nxt;
    prod_r      <= $signed(act_rdata) * $signed(wgt_rdata);
    if (out_load) begin
      out_status_r <= load_status;
      out_rows_r   <= load_rows;
      out_result_r <= load_result;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_rows_done = out_rows_r;
  assign out_result    = out_result_r;

  // words are only taken while idle
  a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |-> state_r == ST_IDLE) else $error("word accepted while busy");

  // a failed run reports no rows
  a_fail_rows: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_status_r |-> out_rows_r == '0) else $error("failed run with rows");

  // a read goes to the capture state next cycle
  a_read_seq: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_op == OP_READ |=> state_r == ST_READ) else $error("read sequence");

  // the clearing pass never admits a word
  a_clear_stall: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_CLEAR |-> in_stall) else $error("word during clear");

endmodule
`default_nettype wire

@@ rtl/core/rexmm_ram.sv @@
// ----------------------------------------------------------------------------
// rexmm_ram
// generic simple dual port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
`default_nettype none
module rexmm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire
